/* rtl/lptrd_pkg.sv */
// Shared types and constants for the length-prefixed text record decoder.
// Holds the command format passed from the front end to the output sequencer.
// No dependencies.
package lptrd_pkg;

    localparam logic [15:0] MAGIC_MZ = 16'h5A4D;
    localparam logic [15:0] MAGIC_ZM = 16'h4D5A;

    localparam logic [16:0] PARA_LO_POS = 17'h00008;
    localparam logic [16:0] PARA_HI_POS = 17'h00009;
    localparam logic [16:0] SIG_OFS     = 17'h00127;
    localparam logic [16:0] DATA_OFS    = 17'h001B5;
    localparam logic [16:0] SIG_LEN     = 17'd14;
    localparam logic [16:0] POS_MAX     = 17'h1FFFF;

    localparam logic [7:0] CHR_TAB   = 8'h09;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_LF    = 8'h0A;
    localparam logic [7:0] CHR_EOF   = 8'h1A;

    localparam logic [3:0] TAB_WIDTH = 4'd8;

    localparam logic [1:0] ST_TEXT   = 2'd0;
    localparam logic [1:0] ST_TRUNC  = 2'd1;
    localparam logic [1:0] ST_BADSIG = 2'd2;

    // One request from the front end: a run of main beats, then optional
    // CR LF, then optional end-of-file marker.
    typedef struct packed {
        logic [3:0] main_cnt;
        logic [7:0] main_byte;
        logic [1:0] status;
        logic       main_last;
        logic       crlf;
        logic       eof_mark;
    } cmd_t;

    function automatic logic [7:0] sig_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h41;
            4'd1:    b = 8'h53;
            4'd2:    b = 8'h43;
            4'd3:    b = 8'h32;
            4'd4:    b = 8'h43;
            4'd5:    b = 8'h4F;
            4'd6:    b = 8'h4D;
            4'd7:    b = 8'h20;
            4'd8:    b = 8'h20;
            4'd9:    b = 8'h56;
            4'd10:   b = 8'h31;
            4'd11:   b = 8'h2E;
            4'd12:   b = 8'h37;
            4'd13:   b = 8'h35;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

/* rtl/lptrd_front.sv */
// Front end: parses the file header, checks the signature and classifies
// each record byte into one output request. Depends on lptrd_pkg.
module lptrd_front
    import lptrd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       end_of_stream,
    output logic       push,
    output cmd_t       cmd
);

    typedef enum logic [2:0] {
        PH_MAGIC,
        PH_EXEHDR,
        PH_SIG,
        PH_TODATA,
        PH_COUNT,
        PH_RECORD,
        PH_DONE
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [16:0] pos_reg, pos_next;
    logic [15:0] header_reg, header_next;
    logic [7:0]  held_reg, held_next;
    logic        sig_good_reg, sig_good_next;
    logic [7:0]  remain_reg, remain_next;

    logic [16:0] sig_start;
    logic [16:0] data_start;
    logic [16:0] sig_idx;
    logic [15:0] word;
    logic [7:0]  remain_dec;
    logic        sig_ok;

    assign sig_start  = {1'b0, header_reg} + SIG_OFS;
    assign data_start = {1'b0, header_reg} + DATA_OFS;
    assign sig_idx    = pos_reg - sig_start;
    assign word       = {data_byte, held_reg};
    assign remain_dec = remain_reg - 8'd1;

    always_comb
    begin
        phase_next    = phase_reg;
        pos_next      = pos_reg;
        header_next   = header_reg;
        held_next     = held_reg;
        sig_good_next = sig_good_reg;
        remain_next   = remain_reg;
        cmd           = '0;
        sig_ok        = sig_good_reg;

        if (accept)
        begin
            if (end_of_stream)
            begin
                case (phase_reg)
                    PH_MAGIC, PH_EXEHDR, PH_SIG:
                    begin
                        cmd.main_cnt  = 4'd1;
                        cmd.status    = ST_TRUNC;
                        cmd.main_last = 1'b1;
                    end
                    PH_RECORD:
                    begin
                        cmd.crlf     = 1'b1;
                        cmd.eof_mark = 1'b1;
                    end
                    PH_TODATA, PH_COUNT:
                        cmd.eof_mark = 1'b1;
                    default: ;
                endcase
                // return to start
                phase_next    = PH_MAGIC;
                pos_next      = '0;
                header_next   = '0;
                held_next     = '0;
                sig_good_next = 1'b1;
                remain_next   = '0;
            end
            else
            begin
                if (pos_reg != POS_MAX)
                    pos_next = pos_reg + 17'd1;

                case (phase_reg)
                    PH_MAGIC:
                    begin
                        if (pos_reg == '0)
                            held_next = data_byte;
                        else if (word == MAGIC_MZ || word == MAGIC_ZM)
                            phase_next = PH_EXEHDR;
                        else
                        begin
                            header_next = '0;
                            phase_next  = PH_SIG;
                        end
                    end
                    PH_EXEHDR:
                    begin
                        if (pos_reg == PARA_LO_POS)
                            held_next = data_byte;
                        else if (pos_reg == PARA_HI_POS)
                        begin
                            // paragraphs to bytes, kept to 16 bits
                            header_next = {data_byte[3:0], held_reg, 4'h0};
                            phase_next  = PH_SIG;
                        end
                    end
                    PH_SIG:
                    begin
                        if (pos_reg >= sig_start)
                        begin
                            if (sig_idx < SIG_LEN && data_byte != sig_byte(sig_idx[3:0]))
                                sig_ok = 1'b0;
                            sig_good_next = sig_ok;
                            if (sig_idx >= SIG_LEN - 17'd1)
                            begin
                                if (sig_ok)
                                    phase_next = PH_TODATA;
                                else
                                begin
                                    cmd.main_cnt  = 4'd1;
                                    cmd.status    = ST_BADSIG;
                                    cmd.main_last = 1'b1;
                                    phase_next    = PH_DONE;
                                end
                            end
                        end
                    end
                    PH_TODATA, PH_COUNT:
                    begin
                        // the first byte at the data start is already a count
                        if (phase_reg == PH_COUNT || pos_reg >= data_start)
                        begin
                            remain_next = data_byte;
                            if (data_byte == 8'd0)
                            begin
                                cmd.crlf   = 1'b1;
                                phase_next = PH_COUNT;
                            end
                            else
                                phase_next = PH_RECORD;
                        end
                    end
                    PH_RECORD:
                    begin
                        if (data_byte == CHR_TAB)
                        begin
                            cmd.main_cnt  = TAB_WIDTH;
                            cmd.main_byte = CHR_SPACE;
                        end
                        else
                        begin
                            cmd.main_cnt  = 4'd1;
                            cmd.main_byte = data_byte;
                        end
                        remain_next = remain_dec;
                        if (remain_dec == 8'd0)
                        begin
                            cmd.crlf   = 1'b1;
                            phase_next = PH_COUNT;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    assign push = accept && (cmd.main_cnt != 4'd0 || cmd.crlf || cmd.eof_mark);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_MAGIC;
            pos_reg      <= '0;
            header_reg   <= '0;
            held_reg     <= '0;
            sig_good_reg <= 1'b1;
            remain_reg   <= '0;
        end
        else
        begin
            phase_reg    <= phase_next;
            pos_reg      <= pos_next;
            header_reg   <= header_next;
            held_reg     <= held_next;
            sig_good_reg <= sig_good_next;
            remain_reg   <= remain_next;
        end
    end

`ifndef SYNTH
    // a mismatch report always ends the file
    a_badsig_done: assert property (@(posedge clk) disable iff (!rst_n)
        (push && cmd.status == ST_BADSIG) |=> (phase_reg == PH_DONE))
        else $error("signature mismatch did not close the file");

    a_pos_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && end_of_stream) |=> (pos_reg == '0 && sig_good_reg))
        else $error("end of stream did not return the parser to start");
`endif

endmodule

/* rtl/lptrd_cmd_fifo.sv */
// Short request queue between the front end and the output sequencer.
// Register-based, one write while not full and one read per cycle. Depends on lptrd_pkg.
module lptrd_cmd_fifo
    import lptrd_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("request pushed into a full queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count out of step with pushes");
`endif

endmodule

/* rtl/lptrd_back.sv */
// Output sequencer: expands each queued request into result beats
// (main byte run, CR LF, end marker) behind an output register. Depends on lptrd_pkg.
module lptrd_back
    import lptrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  cmd_t        head_cmd,
    output logic        pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,  // [1:0] status
    output logic        m_axis_tlast   // last
);

    logic [3:0] beat_reg, beat_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic [1:0] status_reg, status_next;
    logic       last_reg, last_next;

    logic [3:0] total;
    logic [3:0] tail_idx;
    logic       in_main;
    logic       final_beat;
    logic       advance;

    assign total      = head_cmd.main_cnt + {2'b00, head_cmd.crlf, 1'b0}
                        + {3'b000, head_cmd.eof_mark};
    assign final_beat = (beat_reg == total - 4'd1);
    assign in_main    = (beat_reg < head_cmd.main_cnt);
    assign tail_idx   = beat_reg - head_cmd.main_cnt;
    assign advance    = head_valid && (!valid_reg || m_axis_tready);
    assign pop        = advance && final_beat;

    always_comb
    begin
        beat_next   = beat_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        status_next = status_reg;
        last_next   = last_reg;

        if (advance)
        begin
            valid_next = 1'b1;
            if (in_main)
            begin
                byte_next   = head_cmd.main_byte;
                status_next = head_cmd.status;
                last_next   = head_cmd.main_last;
            end
            else if (head_cmd.crlf && tail_idx == 4'd0)
            begin
                byte_next   = CHR_CR;
                status_next = ST_TEXT;
                last_next   = 1'b0;
            end
            else if (head_cmd.crlf && tail_idx == 4'd1)
            begin
                byte_next   = CHR_LF;
                status_next = ST_TEXT;
                last_next   = 1'b0;
            end
            else
            begin
                byte_next   = CHR_EOF;
                status_next = ST_TEXT;
                last_next   = 1'b1;
            end
            beat_next = final_beat ? 4'd0 : beat_reg + 4'd1;
        end
        else if (m_axis_tready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            beat_reg  <= beat_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = byte_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tlast  = last_reg;

`ifndef SYNTH
    // the file closes only on an error or on the end marker
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
        (status_reg != ST_TEXT || byte_reg == CHR_EOF))
        else $error("final result is neither an error nor the end marker");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status_reg != ST_TEXT) |-> (byte_reg == 8'h00 && m_axis_tlast))
        else $error("error result carries data or is not final");
`endif

endmodule

/* rtl/length_prefixed_text_record_decoder_core.sv */
// Requests go from the front end through the request queue to the output register.
// Throughput: one input byte per cycle while the request queue has room; the output
// sequencer gives one result per cycle unless the output is stalled, so a tab (eight
// spaces) or a record end (CR LF) holds its queue entry till its results are out.
// Reset (rst_n, asynchronous, active low) clears the parser to the magic check,
// empties the request queue and drops the output valid.
module length_prefixed_text_record_decoder_core
    import lptrd_pkg::*;
#(
    parameter int CMD_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,  // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    output logic [1:0]  m_axis_tuser,  // [1:0] status
    output logic        m_axis_tlast   // last
);

    logic accept;
    logic push;
    cmd_t push_cmd;
    logic full;
    logic pop;
    logic head_valid;
    cmd_t head_cmd;

    assign s_axis_tready = !full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    lptrd_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .data_byte     (s_axis_tdata),
        .end_of_stream (s_axis_tlast),
        .push          (push),
        .cmd           (push_cmd)
    );

    lptrd_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    lptrd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_cmd      (head_cmd),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

/* tb/lptrd_stream_checker.sv */
// Checker for the length-prefixed text record decoder: watches both stream channels,
// predicts the decoded text from the accepted file bytes and compares every result.
// Depends on lptrd_pkg for codes and offsets.
module lptrd_stream_checker
    import lptrd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic        s_axis_tlast,  // end_of_stream
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,  // [7:0] out_byte
    input  logic [1:0]  m_axis_tuser,  // [1:0] status
    input  logic        m_axis_tlast,  // last
    output int          fail_count,
    output int          pending,
    output int          checked
);

    typedef enum logic [2:0] {
        SCAN_MAGIC,
        SCAN_EXEHDR,
        SCAN_SIG,
        SCAN_TODATA,
        SCAN_COUNT,
        SCAN_RECORD,
        SCAN_DONE
    } scan_t;

    typedef struct packed {
        logic [7:0] text;
        logic [1:0] status;
        logic       last;
    } due_beat_t;

    // signature text, first byte in the lowest bits
    localparam logic [111:0] SIG_TABLE = {
        8'h35, 8'h37, 8'h2E, 8'h31, 8'h56, 8'h20, 8'h20,
        8'h4D, 8'h4F, 8'h43, 8'h32, 8'h43, 8'h53, 8'h41
    };

    due_beat_t   text_due_q[$];
    scan_t       scan;
    logic [16:0] file_pos;
    logic [15:0] hdr_len;
    logic [7:0]  low_half;
    logic        sig_ok;
    logic [7:0]  rec_left;

    task automatic restart_scan();
        scan     = SCAN_MAGIC;
        file_pos = '0;
        hdr_len  = '0;
        low_half = '0;
        sig_ok   = 1'b1;
        rec_left = '0;
    endtask

    task automatic queue_beat(input logic [7:0] text, input logic [1:0] status,
                              input logic last);
        due_beat_t beat;
        beat.text   = text;
        beat.status = status;
        beat.last   = last;
        text_due_q.push_back(beat);
    endtask

    task automatic take_count(input logic [7:0] b);
        rec_left = b;
        if (b == 8'h00)
        begin
            queue_beat(CHR_CR, ST_TEXT, 1'b0);
            queue_beat(CHR_LF, ST_TEXT, 1'b0);
        end
        else
        begin
            scan = SCAN_RECORD;
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic eos);
        logic [16:0] pos;
        logic [16:0] sig_at;
        logic [16:0] data_at;
        logic [16:0] idx;
        logic [15:0] word;
        pos     = file_pos;
        sig_at  = {1'b0, hdr_len} + SIG_OFS;
        data_at = {1'b0, hdr_len} + DATA_OFS;
        if (eos)
        begin
            case (scan)
                SCAN_MAGIC, SCAN_EXEHDR, SCAN_SIG:
                    queue_beat(8'h00, ST_TRUNC, 1'b1);
                SCAN_RECORD:
                begin
                    // close the cut-off record before the end marker
                    queue_beat(CHR_CR, ST_TEXT, 1'b0);
                    queue_beat(CHR_LF, ST_TEXT, 1'b0);
                    queue_beat(CHR_EOF, ST_TEXT, 1'b1);
                end
                SCAN_TODATA, SCAN_COUNT:
                    queue_beat(CHR_EOF, ST_TEXT, 1'b1);
                default: ;
            endcase
            restart_scan();
        end
        else
        begin
            if (file_pos != POS_MAX)
                file_pos = file_pos + 17'd1;
            case (scan)
                SCAN_MAGIC:
                begin
                    if (pos == 17'd0)
                        low_half = b;
                    else
                    begin
                        word = {b, low_half};
                        if (word == MAGIC_MZ || word == MAGIC_ZM)
                            scan = SCAN_EXEHDR;
                        else
                        begin
                            hdr_len = '0;
                            scan    = SCAN_SIG;
                        end
                    end
                end
                SCAN_EXEHDR:
                begin
                    if (pos == PARA_LO_POS)
                        low_half = b;
                    else if (pos == PARA_HI_POS)
                    begin
                        // paragraphs to bytes, top nibble drops off
                        hdr_len = {b[3:0], low_half, 4'h0};
                        scan    = SCAN_SIG;
                    end
                end
                SCAN_SIG:
                begin
                    if (pos >= sig_at)
                    begin
                        idx = pos - sig_at;
                        if (idx < SIG_LEN && b != SIG_TABLE[8 * idx[3:0] +: 8])
                            sig_ok = 1'b0;
                        if (idx >= SIG_LEN - 17'd1)
                        begin
                            if (sig_ok)
                                scan = SCAN_TODATA;
                            else
                            begin
                                queue_beat(8'h00, ST_BADSIG, 1'b1);
                                scan = SCAN_DONE;
                            end
                        end
                    end
                end
                SCAN_TODATA:
                begin
                    if (pos >= data_at)
                    begin
                        scan = SCAN_COUNT;
                        take_count(b);
                    end
                end
                SCAN_COUNT:
                    take_count(b);
                SCAN_RECORD:
                begin
                    if (b == CHR_TAB)
                        repeat (TAB_WIDTH) queue_beat(CHR_SPACE, ST_TEXT, 1'b0);
                    else
                        queue_beat(b, ST_TEXT, 1'b0);
                    rec_left = rec_left - 8'd1;
                    if (rec_left == 8'd0)
                    begin
                        queue_beat(CHR_CR, ST_TEXT, 1'b0);
                        queue_beat(CHR_LF, ST_TEXT, 1'b0);
                        scan = SCAN_COUNT;
                    end
                end
                default: ;
            endcase
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at result %0d: %s", checked, what);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        due_beat_t want;
        if (!rst_n)
        begin
            restart_scan();
            text_due_q.delete();
            fail_count = 0;
            checked    = 0;
            pending   <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (text_due_q.size() == 0)
                    report_mismatch($sformatf("unexpected result tdata=%h tuser=%h last=%b",
                                              m_axis_tdata, m_axis_tuser, m_axis_tlast));
                else
                begin
                    want = text_due_q.pop_front();
                    if (m_axis_tdata !== want.text)
                        report_mismatch($sformatf("out_byte %h, expected %h",
                                                  m_axis_tdata, want.text));
                    if (m_axis_tuser !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  m_axis_tuser, want.status));
                    if (m_axis_tlast !== want.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  m_axis_tlast, want.last));
                end
                checked++;
            end
            pending <= text_due_q.size();
        end
    end

endmodule

/* tb/tb.sv */
// Top of the decoder testbench: clock, reset, file-image stimulus and the verdict.
// Depends on lptrd_pkg, length_prefixed_text_record_decoder_core and lptrd_stream_checker.
module tb
    import lptrd_pkg::*;
();

    typedef enum int {
        HDR_PLAIN,
        HDR_MZ,
        HDR_ZM
    } hdr_kind_t;

    localparam int CYCLE_LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // end_of_stream
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic [1:0]  m_axis_tuser;   // [1:0] status
    logic        m_axis_tlast;   // last

    int fail_count;
    int pending;
    int checked;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int cycle_count    = 0;
    int items_sent     = 0;
    int files_sent     = 0;
    int record_items   = 0;

    // file image under construction
    logic [7:0] img_q[$];
    int         img_data_at;
    logic       img_sig_bad;

    always #2 clk = ~clk;

    length_prefixed_text_record_decoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    lptrd_stream_checker chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending),
        .checked       (checked)
    );

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] b, input logic eos);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do @(posedge clk); while (!s_axis_tready);
        items_sent++;
    endtask

    // Lay out magic or non-magic bytes, paragraph count, signature and padding up to the first count byte.
    task automatic build_file(input hdr_kind_t kind, input logic [15:0] para,
                              input int bad_idx);
        logic [15:0] hdr;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  fill;
        logic [7:0]  flip;
        int          sig_at;
        int          k;
        img_q.delete();
        case (kind)
            HDR_MZ:
            begin
                img_q.push_back(MAGIC_MZ[7:0]);
                img_q.push_back(MAGIC_MZ[15:8]);
            end
            HDR_ZM:
            begin
                img_q.push_back(MAGIC_ZM[7:0]);
                img_q.push_back(MAGIC_ZM[15:8]);
            end
            default:
            begin
                do
                begin
                    b0 = 8'($urandom);
                    b1 = 8'($urandom);
                end
                while ({b1, b0} == MAGIC_MZ || {b1, b0} == MAGIC_ZM);
                img_q.push_back(b0);
                img_q.push_back(b1);
            end
        endcase
        if (kind == HDR_PLAIN)
            hdr = '0;
        else
        begin
            while (img_q.size() < PARA_LO_POS)
            begin
                fill = 8'($urandom);
                img_q.push_back(fill);
            end
            img_q.push_back(para[7:0]);
            img_q.push_back(para[15:8]);
            hdr = para << 4;
        end
        sig_at = int'(hdr) + int'(SIG_OFS);
        while (img_q.size() < sig_at)
        begin
            fill = 8'($urandom);
            img_q.push_back(fill);
        end
        for (k = 0; k < SIG_LEN; k++)
        begin
            fill = sig_byte(4'(k));
            if (k == bad_idx)
            begin
                flip = 8'($urandom_range(1, 255));
                fill = fill ^ flip;
            end
            img_q.push_back(fill);
        end
        img_data_at = int'(hdr) + int'(DATA_OFS);
        while (img_q.size() < img_data_at)
        begin
            fill = 8'($urandom);
            img_q.push_back(fill);
        end
        img_sig_bad = (bad_idx >= 0);
    endtask

    task automatic add_random_record();
        int         pick;
        int         cnt;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 88)
            cnt = $urandom_range(8);
        else if (pick < 97)
            cnt = $urandom_range(9, 40);
        else
            cnt = $urandom_range(200, 255);
        img_q.push_back(8'(cnt));
        repeat (cnt)
        begin
            if ($urandom_range(99) < 25)
                b = CHR_TAB;
            else
                b = 8'($urandom);
            img_q.push_back(b);
        end
    endtask

    // Send the first stop bytes of the image, then end the stream.
    task automatic stream_file(input int stop);
        int         k;
        logic [7:0] junk;
        for (k = 0; k < stop; k++)
            push_byte(img_q[k], 1'b0);
        junk = 8'($urandom);
        push_byte(junk, 1'b1);
        if (!img_sig_bad && stop > img_data_at)
            record_items += stop - img_data_at;
        record_items++;
        files_sent++;
    endtask

    task automatic random_file();
        int          pick;
        int          bad_idx;
        int          stop;
        logic [15:0] para;
        hdr_kind_t   kind;
        pick = $urandom_range(9);
        if (pick < 4)
            kind = HDR_PLAIN;
        else if (pick < 7)
            kind = HDR_MZ;
        else
            kind = HDR_ZM;
        // keep the header short; the top nibble is lost in the shift anyway
        para        = 16'($urandom_range(3));
        para[15:12] = 4'($urandom_range(15));
        bad_idx     = ($urandom_range(99) < 15) ? int'($urandom_range(13)) : -1;
        build_file(kind, para, bad_idx);
        repeat ($urandom_range(1, 8)) add_random_record();
        pick = $urandom_range(99);
        if (pick < 5)
            stop = $urandom_range(11);
        else if (pick < 15)
            stop = $urandom_range(img_data_at);
        else if (pick < 35)
            stop = $urandom_range(img_data_at, img_q.size() - 1);
        else
            stop = img_q.size();
        stream_file(stop);
    endtask

    initial
    begin
        int ph;
        int quota;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty file, then a one-byte file
        push_byte(8'hFF, 1'b1);
        files_sent++;
        push_byte(8'h4D, 1'b0);
        push_byte(8'h00, 1'b1);
        files_sent++;

        // magic found, stream ends before the paragraph count is complete
        build_file(HDR_MZ, 16'h0000, -1);
        stream_file(int'(PARA_HI_POS));

        // wrapped paragraph count, empty record, tab and extreme bytes, end at a count
        build_file(HDR_ZM, 16'h1001, -1);
        img_q.push_back(8'h00);
        img_q.push_back(8'h03);
        img_q.push_back(CHR_TAB);
        img_q.push_back(8'h00);
        img_q.push_back(8'hFF);
        img_q.push_back(8'h01);
        img_q.push_back(CHR_TAB);
        stream_file(img_q.size());

        // bad last signature byte; everything after it is dropped
        build_file(HDR_PLAIN, 16'h0000, 13);
        img_q.push_back(8'h02);
        img_q.push_back(8'h41);
        img_q.push_back(8'h42);
        stream_file(img_q.size());

        // good signature, stream ends before data start
        build_file(HDR_PLAIN, 16'h0000, -1);
        stream_file(img_data_at);

        // stream ends in the middle of the signature
        build_file(HDR_PLAIN, 16'h0000, -1);
        stream_file(img_data_at - 'h88);

        // bad first signature byte
        build_file(HDR_PLAIN, 16'h0000, 0);
        stream_file(img_data_at);

        // largest header, record cut off after its first byte
        build_file(HDR_MZ, 16'hFFFF, -1);
        img_q.push_back(8'h02);
        img_q.push_back(8'h41);
        img_q.push_back(CHR_TAB);
        stream_file(img_data_at + 2);

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                end
                default:
                begin
                    send_idle_pct  = 33;
                    recv_stall_pct = 33;
                end
            endcase
            quota = record_items + 43;
            while (record_items < quota)
                random_file();
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("tb: %0d files of %0d bytes streamed, %0d decoded results checked",
                 files_sent, items_sent, checked);
        $display("tb: plain and both magic headers, tabs, empty and cut-off records, %s",
                 "short files and bad signatures under four stall mixes");
        if (fail_count == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
